// File: hw/rtl/kqt_pkg.sv
// ----------------------------------------------------------------------------
// Keyed quantity table package
// Command and status codes and the item record that travels along the chain.
// ----------------------------------------------------------------------------
package kqt_pkg;

  localparam int KEY_W  = 32;
  localparam int QTY_W  = 32;
  localparam int SLOT_W = 7;
  localparam int ENTRIES_DEF = 128;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_UPDATE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [QTY_W-1:0]  amount;
    logic              hit;
    logic [QTY_W-1:0]  qty;
  } tok_t;

endpackage

// File: hw/rtl/kqt_cell.sv
// ----------------------------------------------------------------------------
// Keyed quantity table cell
// Holds one record, compares the passing item against it and forwards the
// item through a register to the next cell.
// ----------------------------------------------------------------------------
module kqt_cell
  import kqt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IDX     = 0,
  localparam int IDX_W  = $clog2(ENTRIES),
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] count_i,
  input  tok_t             tok_i,
  input  logic [IDX_W-1:0] slot_i,
  output tok_t             tok_o,
  output logic [IDX_W-1:0] slot_o
);

  localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(IDX);

  logic [KEY_W-1:0] key_r;
  logic [QTY_W-1:0] qty_r;
  logic [QTY_W-1:0] qty_nxt;
  tok_t             tok_r, tok_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             occupied;
  logic             match;
  logic             key_we;
  logic             qty_we;

  always_comb begin
    occupied = MY_POS < count_i;
    match    = tok_i.valid && occupied && !tok_i.hit && (tok_i.key == key_r);
    tok_nxt  = tok_i;
    slot_nxt = slot_i;
    key_we   = tok_i.valid && (tok_i.op == OP_INSERT) && !tok_i.hit && (MY_POS == count_i);
    qty_we   = key_we;
    qty_nxt  = tok_i.amount;
    if (match) begin
      tok_nxt.hit = 1'b1;
      slot_nxt    = MY_SLOT;
      case (tok_i.op)
        OP_UPDATE: begin
          qty_nxt     = qty_r + tok_i.amount;
          qty_we      = 1'b1;
          tok_nxt.qty = qty_r + tok_i.amount;
        end
        OP_SEARCH: begin
          tok_nxt.qty = qty_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
    slot_r <= slot_nxt;
    if (key_we) begin
      key_r <= tok_i.key;
    end
    if (qty_we) begin
      qty_r <= qty_nxt;
    end
  end

  assign tok_o  = tok_r;
  assign slot_o = slot_r;

endmodule

// File: hw/rtl/keyed_quantity_table_top.sv
// ----------------------------------------------------------------------------
// Keyed quantity table
// Insert, search and update of keyed signed quantities in a row of cells.
//
//   Channel  Handshake          Payload
//   input    start / busy       in_op, in_key, in_amount
//   result   out_valid strobe   out_status, out_slot, out_quantity
//
// An accepted item walks the row of ENTRIES cells, one cell per cycle, and
// its result is registered from the last cell's output and strobed; busy
// falls in that same cycle, so a new item is not taken before the last
// item's result is strobed. Reset clears the entry count and the item in
// flight; the record stores need no clearing. The receiver cannot stall,
// so a result is never held back.
// ----------------------------------------------------------------------------
module keyed_quantity_table_top
  import kqt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_op,
  input  logic signed [KEY_W-1:0]  in_key,
  input  logic signed [QTY_W-1:0]  in_amount,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic signed [QTY_W-1:0]  out_quantity
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

  tok_t             tok   [ENTRIES+1];
  logic [IDX_W-1:0] slot  [ENTRIES+1];
  logic [ENTRIES-1:0] live;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [SLOT_W-1:0] slot_out_r, slot_out_nxt;
  logic [QTY_W-1:0] qty_out_r, qty_out_nxt;
  logic             accept;
  tok_t             fin;

  assign accept = start && !busy_r;

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = accept;
    tok[0].op     = op_t'(in_op);
    tok[0].key    = in_key;
    tok[0].amount = in_amount;
    slot[0]       = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kqt_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count_i (count_r),
      .tok_i   (tok[i]),
      .slot_i  (slot[i]),
      .tok_o   (tok[i+1]),
      .slot_o  (slot[i+1])
    );
    assign live[i] = tok[i+1].valid;
  end

  assign fin = tok[ENTRIES];

  always_comb begin
    status_nxt   = ST_MISSING;
    slot_out_nxt = '0;
    qty_out_nxt  = '0;
    count_nxt    = count_r;
    busy_nxt     = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (fin.valid) begin
      busy_nxt = 1'b0;
    end
    case (fin.op)
      OP_INSERT: begin
        if (count_r == FULL_COUNT) begin
          status_nxt = ST_FULL;
        end else if (fin.hit) begin
          status_nxt = ST_DUP;
        end else begin
          status_nxt   = ST_OK;
          slot_out_nxt = SLOT_W'(count_r);
          qty_out_nxt  = fin.amount;
          if (fin.valid) begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      OP_SEARCH, OP_UPDATE: begin
        if (fin.hit) begin
          status_nxt   = ST_OK;
          slot_out_nxt = SLOT_W'(slot[ENTRIES]);
          qty_out_nxt  = fin.qty;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin.valid;
    end
    status_r   <= status_nxt;
    slot_out_r <= slot_out_nxt;
    qty_out_r  <= qty_out_nxt;
  end

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_slot     = slot_out_r;
  assign out_quantity = qty_out_r;

  a_one_item : assert property (@(posedge clk) disable iff (!rst_n) $onehot0(live))
    else $error("more than one item in the cell row");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count beyond table size");

  a_result_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy_r))
    else $error("result without an item in flight");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && !out_valid_r)
    else $error("accepted item did not raise busy");

endmodule
